### sv/bafe_pkg.sv
// ----------------------------------------------------------------------------
// bafe_pkg
// Shared types and codes for the advertising field extractor.
// ----------------------------------------------------------------------------
package bafe_pkg;

  // Depth of the queue between the front and back parts, as address bits
  localparam int QueueAddrW = 2;

  // Structure kinds decoded from the type byte
  localparam logic [1:0] STRUCT_OTHER = 2'd0;
  localparam logic [1:0] STRUCT_NAME  = 2'd1;
  localparam logic [1:0] STRUCT_MAKER = 2'd2;
  localparam logic [1:0] STRUCT_UUID  = 2'd3;

  // Result element kinds
  localparam logic [2:0] ELEM_NONE    = 3'd0;
  localparam logic [2:0] ELEM_NAME    = 3'd1;
  localparam logic [2:0] ELEM_COMPANY = 3'd2;
  localparam logic [2:0] ELEM_MAKER   = 3'd3;
  localparam logic [2:0] ELEM_UUID    = 3'd4;

  // Advertising type codes
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_MAKER      = 8'hFF;
  localparam logic [7:0] AD_UUID_FULL  = 8'h03;
  localparam logic [7:0] AD_UUID_PART  = 8'h02;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_NAME_LIMIT  = 2'd0;
  localparam logic [1:0] REG_MAKER_LIMIT = 2'd1;
  localparam logic [1:0] REG_UUID_CAP    = 2'd2;

  localparam logic [7:0] NAME_LIMIT_RST  = 8'd32;
  localparam logic [7:0] MAKER_LIMIT_RST = 8'd31;
  localparam logic [3:0] UUID_CAP_RST    = 4'd10;

  // One classified byte, as handed from front to back
  typedef struct packed {
    logic [7:0] data;      // raw byte
    logic       restart;   // first byte of a packet
    logic       live;      // position lies inside the packet
    logic       last;      // last byte of the packet
    logic       brk;       // as a length byte: zero or overrunning
    logic [1:0] ad_kind;   // as a type byte: decoded structure kind
  } bafe_tok_t;

  typedef struct packed {
    logic [7:0] name_limit;
    logic [7:0] maker_limit;
    logic [3:0] uuid_cap;
  } bafe_cfg_t;

endpackage

### sv/bafe_front.sv
// ----------------------------------------------------------------------------
// bafe_front
// Accepts input beats, tracks byte position and classifies each byte.
// ----------------------------------------------------------------------------
module bafe_front
  import bafe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic [7:0] in_plen,
  input  logic       in_first,
  input  logic       q_full,
  output logic       in_ready,
  output logic       q_push,
  output bafe_tok_t  q_tok
);

  logic [7:0] byte_position;
  logic [7:0] pos;
  logic [8:0] pos_inc;
  logic [8:0] len_end;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    pos     = in_first ? 8'd0 : byte_position;
    pos_inc = {1'b0, pos} + 9'd1;
    len_end = {1'b0, pos} + {1'b0, in_byte};

    q_tok.data    = in_byte;
    q_tok.restart = in_first;
    q_tok.live    = pos < in_plen;
    q_tok.last    = pos_inc == {1'b0, in_plen};
    q_tok.brk     = (in_byte == 8'd0) || (len_end >= {1'b0, in_plen});
    case (in_byte)
      AD_NAME_FULL, AD_NAME_SHORT: q_tok.ad_kind = STRUCT_NAME;
      AD_MAKER:                    q_tok.ad_kind = STRUCT_MAKER;
      AD_UUID_FULL, AD_UUID_PART:  q_tok.ad_kind = STRUCT_UUID;
      default:                     q_tok.ad_kind = STRUCT_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
    end else if (q_push) begin
      // saturate at the top of the range
      byte_position <= (pos == 8'hFF) ? 8'hFF : pos_inc[7:0];
    end
  end

endmodule

### sv/bafe_fifo.sv
// ----------------------------------------------------------------------------
// bafe_fifo
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module bafe_fifo
  import bafe_pkg::*;
#(
  parameter int ADDR_W = QueueAddrW
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bafe_tok_t push_tok,
  input  logic      pop,
  output bafe_tok_t pop_tok,
  output logic      full,
  output logic      empty
);

  localparam int Depth = 1 << ADDR_W;

  bafe_tok_t        mem [Depth];
  logic [ADDR_W:0]  wr_ptr;
  logic [ADDR_W:0]  rd_ptr;

  assign empty   = wr_ptr == rd_ptr;
  assign full    = (wr_ptr[ADDR_W] != rd_ptr[ADDR_W]) &&
                   (wr_ptr[ADDR_W-1:0] == rd_ptr[ADDR_W-1:0]);
  assign pop_tok = mem[rd_ptr[ADDR_W-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[ADDR_W-1:0]] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

### sv/bafe_back.sv
// ----------------------------------------------------------------------------
// bafe_back
// Walks the length-type-value structures and drives the result register.
// ----------------------------------------------------------------------------
module bafe_back
  import bafe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bafe_cfg_t   cfg,
  input  logic        q_empty,
  input  bafe_tok_t   q_tok,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_value,
  output logic [7:0]  out_index,
  output logic        out_last,
  output logic        out_stopped
);

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  logic [7:0] remaining, remaining_next, rem_c;
  logic [1:0] phase, phase_next, phase_c;
  logic [1:0] skind, skind_next, skind_c;
  logic       accepted, accepted_next, acc_c;
  logic [7:0] offset, offset_next, off_c;
  logic [7:0] held, held_next, held_c;
  logic [3:0] uuids, uuids_next, uuids_c;
  logic       halted, halted_next, halt_c;

  logic [2:0]  res_kind;
  logic [15:0] res_value;
  logic [7:0]  res_index;
  logic [7:0]  n;
  logic [7:0]  rem_dec;
  logic        emit;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_comb begin
    // a first byte wipes the packet state before it is parsed
    if (q_tok.restart) begin
      rem_c = 8'd0; phase_c = PH_LENGTH; skind_c = STRUCT_OTHER; acc_c = 1'b0;
      off_c = 8'd0; held_c = 8'd0; uuids_c = 4'd0; halt_c = 1'b0;
    end else begin
      rem_c = remaining; phase_c = phase; skind_c = skind; acc_c = accepted;
      off_c = offset; held_c = held; uuids_c = uuids; halt_c = halted;
    end

    remaining_next = rem_c;
    phase_next     = phase_c;
    skind_next     = skind_c;
    accepted_next  = acc_c;
    offset_next    = off_c;
    held_next      = held_c;
    uuids_next     = uuids_c;
    halted_next    = halt_c;
    res_kind       = ELEM_NONE;
    res_value      = 16'd0;
    res_index      = 8'd0;
    n              = rem_c - 8'd1;
    rem_dec        = rem_c - 8'd1;

    if (q_tok.live && !halt_c) begin
      unique case (phase_c)
        PH_TYPE: begin
          skind_next = q_tok.ad_kind;
          case (q_tok.ad_kind)
            STRUCT_NAME:  accepted_next = (n != 8'd0) && (n < cfg.name_limit);
            STRUCT_MAKER: accepted_next = (n > 8'd2) &&
                                          ((n - 8'd2) <= cfg.maker_limit);
            STRUCT_UUID:  accepted_next = 1'b1;
            default:      accepted_next = 1'b0;
          endcase
          remaining_next = n;
          offset_next    = 8'd0;
          phase_next     = (n == 8'd0) ? PH_LENGTH : PH_DATA;
        end
        PH_DATA: begin
          case (skind_c)
            STRUCT_NAME: begin
              if (acc_c) begin
                res_kind  = ELEM_NAME;
                res_value = {8'd0, q_tok.data};
                res_index = off_c;
              end
            end
            STRUCT_MAKER: begin
              if (off_c == 8'd0) begin
                held_next = q_tok.data;
              end else if (off_c == 8'd1) begin
                res_kind  = ELEM_COMPANY;
                res_value = {q_tok.data, held_c};
              end else if (acc_c) begin
                res_kind  = ELEM_MAKER;
                res_value = {8'd0, q_tok.data};
                res_index = off_c - 8'd2;
              end
            end
            STRUCT_UUID: begin
              if (!off_c[0]) begin
                held_next = q_tok.data;
              end else if (uuids_c < cfg.uuid_cap) begin
                res_kind   = ELEM_UUID;
                res_value  = {q_tok.data, held_c};
                res_index  = {1'b0, off_c[7:1]};
                uuids_next = uuids_c + 4'd1;
              end
            end
            default: ;
          endcase
          offset_next    = off_c + 8'd1;
          remaining_next = rem_dec;
          if (rem_dec == 8'd0) phase_next = PH_LENGTH;
        end
        default: begin
          if (q_tok.brk) begin
            halted_next = 1'b1;
          end else begin
            remaining_next = q_tok.data;
            phase_next     = PH_TYPE;
          end
        end
      endcase
    end

    emit = q_tok.live && ((res_kind != ELEM_NONE) || q_tok.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 8'd0;
      phase     <= PH_LENGTH;
      skind     <= STRUCT_OTHER;
      accepted  <= 1'b0;
      offset    <= 8'd0;
      held      <= 8'd0;
      uuids     <= 4'd0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        remaining <= remaining_next;
        phase     <= phase_next;
        skind     <= skind_next;
        accepted  <= accepted_next;
        offset    <= offset_next;
        held      <= held_next;
        uuids     <= uuids_next;
        halted    <= halted_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_kind    <= res_kind;
      out_value   <= res_value;
      out_index   <= res_index;
      out_last    <= q_tok.last;
      out_stopped <= halted_next;
    end
  end

endmodule

### sv/ble_adv_field_extractor.sv
// ----------------------------------------------------------------------------
// ble_adv_field_extractor
// Extracts names, company IDs, maker bytes and 16-bit UUIDs from BLE
// advertising payloads.
// ----------------------------------------------------------------------------
// One payload byte is taken per beat and the block sustains one byte per
// cycle while the queue has room and m_tready does not hold the output:
// the front part classifies each byte combinationally and registers the
// byte position, a queue of 2**QUEUE_AW entries decouples it from the
// back part, which applies the per-structure state update and loads the
// result register. A byte's result passes through a queue entry and the
// result register. Bytes that make no element and are not the packet's
// last byte give no output beat. The user writes registers through the APB
// port only while the stream is idle; the block itself does not enforce it.
module ble_adv_field_extractor
  import bafe_pkg::*;
#(
  parameter int QUEUE_AW = QueueAddrW
)
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] packet_length
  input  logic [0:0]  s_tuser,   // [0] first_of_packet
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] element_value, [23:16] element_index
  output logic [3:0]  m_tuser,   // [2:0] element_kind, [3] stopped_early
  output logic        m_tlast,   // end_of_packet
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bafe_cfg_t cfg;
  bafe_tok_t push_tok;
  bafe_tok_t pop_tok;
  logic      push, pop, full, empty;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.name_limit  <= NAME_LIMIT_RST;
      cfg.maker_limit <= MAKER_LIMIT_RST;
      cfg.uuid_cap    <= UUID_CAP_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_NAME_LIMIT:  cfg.name_limit  <= pwdata[7:0];
        REG_MAKER_LIMIT: cfg.maker_limit <= pwdata[7:0];
        REG_UUID_CAP:    cfg.uuid_cap    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NAME_LIMIT:  prdata = {24'd0, cfg.name_limit};
      REG_MAKER_LIMIT: prdata = {24'd0, cfg.maker_limit};
      REG_UUID_CAP:    prdata = {28'd0, cfg.uuid_cap};
      default:         prdata = 32'd0;
    endcase
  end

  bafe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata[7:0]),
    .in_plen  (s_tdata[15:8]),
    .in_first (s_tuser[0]),
    .q_full   (full),
    .in_ready (s_tready),
    .q_push   (push),
    .q_tok    (push_tok)
  );

  bafe_fifo #(
    .ADDR_W (QUEUE_AW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .full     (full),
    .empty    (empty)
  );

  bafe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (empty),
    .q_tok       (pop_tok),
    .q_pop       (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser[2:0]),
    .out_value   (m_tdata[15:0]),
    .out_index   (m_tdata[23:16]),
    .out_last    (m_tlast),
    .out_stopped (m_tuser[3])
  );

endmodule
